### hw/rtl/div64_pkg.sv
// Shared definitions for the 64-bit signed/unsigned divider.
// Holds the operand width, counter width and the controller-to-datapath command type.
// No dependencies.
package div64_pkg;

  localparam int DATA_WIDTH = 64;
  localparam int PORT_WIDTH = 64;
  localparam int CNT_WIDTH  = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [CNT_WIDTH-1:0]  cnt_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fix;
  } div_cmd_t;

endpackage

### hw/rtl/div64_dp.sv
// Datapath of the divider: operand magnitudes, shift-subtract iteration,
// sign fix-up and the result register. Depends on div64_pkg.
module div64_dp
  import div64_pkg::*;
(
  input  logic                  clk_i,
  input  div_cmd_t              cmd_i,
  input  logic                  req_type_i,
  input  logic [PORT_WIDTH-1:0] dividend_i,
  input  logic [PORT_WIDTH-1:0] divisor_i,
  output logic [PORT_WIDTH-1:0] quotient_o,
  output logic [PORT_WIDTH-1:0] remainder_o,
  output logic                  div_by_zero_o
);

  data_t n_in;
  data_t d_in;
  logic  n_neg;
  logic  d_neg;

  data_t quo_q, quo_d;
  data_t rem_q, rem_d;
  data_t div_q, div_d;
  logic  neg_quo_q, neg_quo_d;
  logic  neg_rem_q, neg_rem_d;
  logic  dz_q, dz_d;

  logic [DATA_WIDTH:0] rem_shift;
  logic [DATA_WIDTH:0] diff;

  logic [PORT_WIDTH-1:0] quo_out_q, quo_out_d;
  logic [PORT_WIDTH-1:0] rem_out_q, rem_out_d;
  logic                  dz_out_q, dz_out_d;

  data_t quo_fix;
  data_t rem_fix;

  assign n_in  = dividend_i[DATA_WIDTH-1:0];
  assign d_in  = divisor_i[DATA_WIDTH-1:0];
  assign n_neg = req_type_i & n_in[DATA_WIDTH-1];
  assign d_neg = req_type_i & d_in[DATA_WIDTH-1];

  assign rem_shift = {rem_q, quo_q[DATA_WIDTH-1]};
  assign diff      = rem_shift - {1'b0, div_q};

  assign quo_fix = neg_quo_q ? (data_t'(0) - quo_q) : quo_q;
  assign rem_fix = neg_rem_q ? (data_t'(0) - rem_q) : rem_q;

  always_comb begin
    quo_d     = quo_q;
    rem_d     = rem_q;
    div_d     = div_q;
    neg_quo_d = neg_quo_q;
    neg_rem_d = neg_rem_q;
    dz_d      = dz_q;
    quo_out_d = quo_out_q;
    rem_out_d = rem_out_q;
    dz_out_d  = dz_out_q;
    if (cmd_i.load) begin
      quo_d     = n_neg ? (data_t'(0) - n_in) : n_in;
      div_d     = d_neg ? (data_t'(0) - d_in) : d_in;
      rem_d     = '0;
      neg_quo_d = n_neg ^ d_neg;
      neg_rem_d = n_neg;
      dz_d      = (d_in == '0);
    end
    if (cmd_i.step) begin
      if (!diff[DATA_WIDTH]) begin
        rem_d = diff[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_d = rem_shift[DATA_WIDTH-1:0];
        quo_d = {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd_i.fix) begin
      quo_out_d = dz_q ? '0 : PORT_WIDTH'(quo_fix);
      rem_out_d = dz_q ? '0 : PORT_WIDTH'(rem_fix);
      dz_out_d  = dz_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    div_q     <= div_d;
    neg_quo_q <= neg_quo_d;
    neg_rem_q <= neg_rem_d;
    dz_q      <= dz_d;
    quo_out_q <= quo_out_d;
    rem_out_q <= rem_out_d;
    dz_out_q  <= dz_out_d;
  end

  assign quotient_o    = quo_out_q;
  assign remainder_o   = rem_out_q;
  assign div_by_zero_o = dz_out_q;

endmodule

### hw/rtl/div64_ctrl.sv
// Controller of the divider: sequences load, iteration and fix-up, and owns
// both handshakes and the iteration counter. Depends on div64_pkg.
module div64_ctrl
  import div64_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output div_cmd_t cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFix  = 2'd2;

  logic [1:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign in_stall_o = (state_q != StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = cnt_t'(DATA_WIDTH - 1);
          state_d    = StRun;
        end
      end
      StRun: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q - cnt_t'(1);
        if (cnt_q == '0) begin
          state_d = StFix;
        end
      end
      StFix: begin
        if (out_free) begin
          cmd_o.fix   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/divider_64bit_signed_unsigned_unit.sv
// Top level of the 64-bit restoring shift-and-subtract divider, signed or unsigned.
// Instantiates div64_ctrl and div64_dp; depends on div64_pkg.
//
// Each transaction carries a dividend, a divisor and a mode (0 unsigned, 1 signed)
// and yields one transaction with quotient, remainder and a divide-by-zero flag.
// Quotients truncate toward zero and a signed remainder takes the dividend's sign;
// a zero divisor returns zero for both with the flag set. A transaction runs as a load
// of the magnitudes, one shift-subtract step per quotient bit through the single shared
// subtractor, and the sign fix-up into the result register. A new transaction is taken
// while the previous result still waits in that register.
module divider_64bit_signed_unsigned_unit
  import div64_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  req_type_i,
  input  logic [PORT_WIDTH-1:0] dividend_i,
  input  logic [PORT_WIDTH-1:0] divisor_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PORT_WIDTH-1:0] quotient_o,
  output logic [PORT_WIDTH-1:0] remainder_o,
  output logic                  div_by_zero_o
);

  div_cmd_t cmd;

  div64_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  div64_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .quotient_o    (quotient_o),
    .remainder_o   (remainder_o),
    .div_by_zero_o (div_by_zero_o)
  );

endmodule

### verif/divider_64bit_signed_unsigned_unit_test.sv
// Self-checking testbench for divider_64bit_signed_unsigned_unit: directed and random division
// transactions with random idling on both channels, checked against a scoreboard predictor.
// Depends on div64_pkg and the divider RTL only.
`timescale 1ns / 100ps

module divider_64bit_signed_unsigned_unit_test;
  import div64_pkg::*;

  localparam logic REQ_UNSIGNED = 1'b0;
  localparam logic REQ_SIGNED   = 1'b1;
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   RANDOM_ITEMS = 650;
  localparam int   REPORT_MAX   = 10;

  typedef struct packed {
    logic [PORT_WIDTH-1:0] quotient;
    logic [PORT_WIDTH-1:0] remainder;
    logic                  div_by_zero;
  } div_result_t;

  class div_scoreboard;
    div_result_t expected_results[$];
    int unsigned mismatch_count;

    function div_result_t predict_division(logic mode, logic [PORT_WIDTH-1:0] a,
                                           logic [PORT_WIDTH-1:0] b);
      div_result_t res;
      data_t       n;
      data_t       d;
      data_t       n_mag;
      data_t       d_mag;
      data_t       q;
      data_t       r;
      logic        n_neg;
      logic        d_neg;
      res   = '0;
      n     = a[DATA_WIDTH-1:0];
      d     = b[DATA_WIDTH-1:0];
      n_neg = (mode == REQ_SIGNED) && n[DATA_WIDTH-1];
      d_neg = (mode == REQ_SIGNED) && d[DATA_WIDTH-1];
      if (d == '0) begin
        res.div_by_zero = 1'b1;
        return res;
      end
      n_mag = n_neg ? -n : n;
      d_mag = d_neg ? -d : d;
      q     = n_mag / d_mag;
      r     = n_mag % d_mag;
      if (n_neg != d_neg) begin
        q = -q;
      end
      if (n_neg) begin
        r = -r;
      end
      res.quotient[DATA_WIDTH-1:0]  = q;
      res.remainder[DATA_WIDTH-1:0] = r;
      return res;
    endfunction

    function void note_request(logic mode, logic [PORT_WIDTH-1:0] a, logic [PORT_WIDTH-1:0] b);
      expected_results.push_back(predict_division(mode, a, b));
    endfunction

    function void check_result(logic [PORT_WIDTH-1:0] q, logic [PORT_WIDTH-1:0] r, logic z);
      div_result_t exp_res;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected result transaction: q=%h r=%h dbz=%b", q, r, z);
        end
        return;
      end
      exp_res = expected_results.pop_front();
      if (q !== exp_res.quotient || r !== exp_res.remainder || z !== exp_res.div_by_zero) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("mismatch: got q=%h r=%h dbz=%b, expected q=%h r=%h dbz=%b",
                   q, r, z, exp_res.quotient, exp_res.remainder, exp_res.div_by_zero);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  req_type_i;
  logic [PORT_WIDTH-1:0] dividend_i;
  logic [PORT_WIDTH-1:0] divisor_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [PORT_WIDTH-1:0] quotient_o;
  logic [PORT_WIDTH-1:0] remainder_o;
  logic                  div_by_zero_o;

  div_scoreboard sb = new();
  logic          tx_idle_en;
  logic          rx_idle_en;
  int unsigned   stall_left;
  int unsigned   cycle_count;

  divider_64bit_signed_unsigned_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .dividend_i    (dividend_i),
    .divisor_i     (divisor_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .quotient_o    (quotient_o),
    .remainder_o   (remainder_o),
    .div_by_zero_o (div_by_zero_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [PORT_WIDTH-1:0] sval(input longint v);
    data_t t;
    logic [PORT_WIDTH-1:0] p;
    t = data_t'(v);
    p = '0;
    p[DATA_WIDTH-1:0] = t;
    return p;
  endfunction

  function automatic logic [PORT_WIDTH-1:0] rand_operand();
    logic [PORT_WIDTH-1:0] v;
    logic [PORT_WIDTH-1:0] most_neg;
    most_neg = '0;
    most_neg[DATA_WIDTH-1] = 1'b1;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: v = v >> $urandom_range(0, PORT_WIDTH - 1);
      2: v = ~(v >> $urandom_range(0, PORT_WIDTH - 1));
      3: v = PORT_WIDTH'($urandom_range(0, 15));
      4: v = sval(-longint'($urandom_range(1, 15)));
      default: begin
        case ($urandom_range(0, 3))
          0: v = most_neg;
          1: v = sval(-1);
          2: v = sval(1);
          default: v = sval(-1) ^ most_neg;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_request(input logic mode, input logic [PORT_WIDTH-1:0] a,
                              input logic [PORT_WIDTH-1:0] b);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    req_type_i = mode;
    dividend_i = a;
    divisor_i  = b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(mode, a, b);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
      if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(quotient_o, remainder_o, div_by_zero_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("divider_64bit_signed_unsigned_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    logic [PORT_WIDTH-1:0] most_neg;
    logic [PORT_WIDTH-1:0] all_ones;
    logic [PORT_WIDTH-1:0] divisor;
    most_neg = '0;
    most_neg[DATA_WIDTH-1] = 1'b1;
    all_ones = sval(-1);
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_UNSIGNED;
    dividend_i  = '0;
    divisor_i   = '0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    cycle_count = 0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    send_request(REQ_UNSIGNED, sval(12345), '0);
    send_request(REQ_SIGNED, most_neg, '0);
    send_request(REQ_UNSIGNED, '0, sval(1));
    send_request(REQ_UNSIGNED, all_ones, sval(1));
    send_request(REQ_UNSIGNED, all_ones, all_ones);
    send_request(REQ_UNSIGNED, sval(1), all_ones);
    send_request(REQ_UNSIGNED, all_ones, most_neg);
    send_request(REQ_UNSIGNED, all_ones, sval(3));
    send_request(REQ_SIGNED, most_neg, sval(-1));
    send_request(REQ_SIGNED, most_neg, sval(1));
    send_request(REQ_SIGNED, most_neg, most_neg);
    send_request(REQ_SIGNED, sval(-1), sval(-1));
    send_request(REQ_SIGNED, sval(-7), sval(2));
    send_request(REQ_SIGNED, sval(7), sval(-2));
    send_request(REQ_SIGNED, sval(-7), sval(-2));
    send_request(REQ_SIGNED, sval(7), sval(2));
    send_request(REQ_SIGNED, sval(3), sval(-10));
    send_request(REQ_SIGNED, '0, sval(-5));
    send_request(REQ_SIGNED, most_neg ^ all_ones, most_neg);
    send_request(REQ_UNSIGNED, sval(1000), sval(1001));
    send_request(REQ_UNSIGNED, {$urandom, $urandom}, sval(1) << (DATA_WIDTH - 2));
    send_request(REQ_SIGNED, {$urandom, $urandom}, {$urandom, $urandom});

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      tx_idle_en = (i < 250) || (i >= 400 && i < 550);
      rx_idle_en = tx_idle_en;
      if (i == 300) begin
        in_valid_i = 1'b0;
        wait_drained();
      end
      divisor = ($urandom_range(0, 24) == 0) ? '0 : rand_operand();
      send_request($urandom_range(0, 1) ? REQ_SIGNED : REQ_UNSIGNED, rand_operand(), divisor);
    end

    in_valid_i = 1'b0;
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("divider_64bit_signed_unsigned_unit_test OK");
    end else begin
      $display("divider_64bit_signed_unsigned_unit_test NOT OK");
    end
    $finish;
  end

endmodule
